FILE: hw/rtl/gss_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gss_pkg: shared definitions for the geometric series sum block
// Field widths, the prime and its Barrett constant, and the command and
// status bundles between the controller and the datapath.
// ============================================================================
package gss_pkg;

   // Field widths.
   localparam int BASE_W  = 30;
   localparam int COUNT_W = 32;
   localparam int PROD_W  = 2 * BASE_W;
   // Width of the quotient estimate and of the high slice that feeds it.
   localparam int QH_W    = 31;
   // Width of the partial remainder, which stays below three times the prime.
   localparam int RED_W   = 32;

   // Default number of term count bits that are scanned.
   localparam int COUNT_BITS_DEFAULT = 32;

   // The modulus and the Barrett reciprocal floor(2^60 / prime).
   localparam logic [BASE_W-1:0] PRIME     = 30'd1000000007;
   localparam logic [QH_W-1:0]   BARRETT_M = QH_W'((64'd1 << PROD_W) / 64'(PRIME));

   // Which round of modular products is being issued or written back.
   typedef enum logic {
      OP_DOUBLE = 1'b0,
      OP_APPEND = 1'b1
   } op_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;
      logic        issue;
      op_kind_type op;
      logic        writeback;
      logic        shift;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cur_bit;
      logic res_valid;
   } dp_status_type;

endpackage

FILE: hw/rtl/gss_modmul.sv
`timescale 1ns / 1ps
// ============================================================================
// gss_modmul: pipelined modular multiplier
// Four stages: product, Barrett quotient estimate, partial remainder, and a
// final correction that brings the remainder below the prime.
// ============================================================================
module gss_modmul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [gss_pkg::BASE_W-1:0] op_x,
   input  logic [gss_pkg::BASE_W-1:0] op_y,
   output logic                       out_valid,
   output logic [gss_pkg::BASE_W-1:0] result
);

   localparam int PW   = gss_pkg::PROD_W;
   localparam int QW   = gss_pkg::QH_W;
   localparam int RW   = gss_pkg::RED_W;
   localparam int BW   = gss_pkg::BASE_W;
   localparam int QMW  = 2 * QW;
   localparam int QPW  = QW + BW;
   localparam logic [RW-1:0] PRIME_X1 = RW'(gss_pkg::PRIME);
   localparam logic [RW-1:0] PRIME_X2 = RW'(64'(gss_pkg::PRIME) * 64'd2);

   logic [PW-1:0]  prod_ff, prod_in;
   logic [QMW-1:0] qm;
   logic [QW-1:0]  q_ff, q_in;
   logic [RW-1:0]  lo_ff, lo_in;
   logic [QPW-1:0] qp;
   logic [RW-1:0]  r0_ff, r0_in;
   logic [RW-1:0]  corr;
   logic [BW-1:0]  res_ff, res_in;
   logic [3:0]     vld_ff, vld_in;

   // Stage one: the full product of the operands.
   assign prod_in = PW'(op_x) * PW'(op_y);

   // Stage two: quotient estimate from the high part of the product.
   assign qm    = QMW'(prod_ff[PW-1:PW-QW]) * QMW'(gss_pkg::BARRETT_M);
   assign q_in  = qm[QMW-1:QMW-QW];
   assign lo_in = prod_ff[RW-1:0];

   // Stage three: the remainder is below three primes, so the low bits suffice.
   assign qp    = QPW'(q_ff) * QPW'(gss_pkg::PRIME);
   assign r0_in = lo_ff - qp[RW-1:0];

   // Stage four: subtract the prime once or twice, or not at all.
   always_comb begin
      priority if (r0_ff >= PRIME_X2) begin
         corr = r0_ff - PRIME_X2;
      end else if (r0_ff >= PRIME_X1) begin
         corr = r0_ff - PRIME_X1;
      end else begin
         corr = r0_ff;
      end
   end
   assign res_in = corr[BW-1:0];

   // Valid bits travel alongside the data.
   assign vld_in = {vld_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      q_ff    <= q_in;
      lo_ff   <= lo_in;
      r0_ff   <= r0_in;
      res_ff  <= res_in;
   end

   assign out_valid = vld_ff[3];
   assign result    = res_ff;

   // A product leaves the pipeline once it has passed the product, quotient, remainder and correction registers.
   assert property (@(posedge clock) disable iff (reset) in_valid |-> ##4 out_valid)
      else $error("modular product did not emerge after four cycles");

   // Every finished product is fully reduced.
   assert property (@(posedge clock) disable iff (reset) out_valid |-> result < gss_pkg::PRIME)
      else $error("modular product not below the prime");

endmodule

FILE: hw/rtl/gss_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// gss_datapath: running power and sum registers with two multiplier lanes
// Holds the reduced ratio, the running sum and power and the term count
// shift register; the sum lane and the power lane work side by side.
// ============================================================================
module gss_datapath #(
   parameter int COUNT_BITS = gss_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gss_pkg::dp_cmd_type           cmd,
   output gss_pkg::dp_status_type        status,
   input  logic [gss_pkg::BASE_W-1:0]    req_base,
   input  logic [gss_pkg::COUNT_W-1:0]   req_term_count,
   output logic [gss_pkg::BASE_W-1:0]    rsp_series_sum
);

   localparam int BW    = gss_pkg::BASE_W;
   localparam int EXT_W = (COUNT_BITS > gss_pkg::COUNT_W) ? COUNT_BITS : gss_pkg::COUNT_W;

   logic [BW-1:0]         a_ff, a_in;
   logic [BW-1:0]         s_ff, s_in;
   logic [BW-1:0]         p_ff, p_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [EXT_W-1:0]      count_ext;
   logic [BW-1:0]         base_red;
   logic [BW-1:0]         x0, y0, x1, y1;
   logic [BW-1:0]         r0, r1;
   logic                  v0, v1;

   // Adds one modulo the prime to a value already below it.
   function automatic logic [BW-1:0] inc_mod(input logic [BW-1:0] v);
      logic [BW:0] sum;
      sum = (BW+1)'(v) + (BW+1)'(1);
      if (sum == (BW+1)'(gss_pkg::PRIME)) begin
         return '0;
      end
      return sum[BW-1:0];
   endfunction

   // The ratio can exceed the prime by less than one prime.
   assign base_red  = (req_base >= gss_pkg::PRIME) ? req_base - gss_pkg::PRIME : req_base;
   assign count_ext = EXT_W'(req_term_count);

   // Operand selection: doubling forms s*(1+p) and p*p, appending a*s and p*a.
   always_comb begin
      unique case (cmd.op)
         gss_pkg::OP_DOUBLE: begin
            x0 = s_ff;
            y0 = inc_mod(p_ff);
            x1 = p_ff;
            y1 = p_ff;
         end
         gss_pkg::OP_APPEND: begin
            x0 = a_ff;
            y0 = s_ff;
            x1 = p_ff;
            y1 = a_ff;
         end
         default: begin
            x0 = s_ff;
            y0 = s_ff;
            x1 = p_ff;
            y1 = p_ff;
         end
      endcase
   end

   gss_modmul u_sum_lane (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd.issue),
      .op_x      (x0),
      .op_y      (y0),
      .out_valid (v0),
      .result    (r0)
   );

   gss_modmul u_pow_lane (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd.issue),
      .op_x      (x1),
      .op_y      (y1),
      .out_valid (v1),
      .result    (r1)
   );

   // Register updates: load a new item, write back a round, advance a bit.
   always_comb begin
      a_in     = a_ff;
      s_in     = s_ff;
      p_in     = p_ff;
      count_in = count_ff;
      if (cmd.load) begin
         a_in     = base_red;
         s_in     = '0;
         p_in     = BW'(1);
         count_in = count_ext[COUNT_BITS-1:0];
      end else begin
         if (cmd.writeback) begin
            unique case (cmd.op)
               gss_pkg::OP_DOUBLE: begin
                  s_in = r0;
                  p_in = r1;
               end
               gss_pkg::OP_APPEND: begin
                  s_in = inc_mod(r0);
                  p_in = r1;
               end
               default: begin
                  s_in = s_ff;
                  p_in = p_ff;
               end
            endcase
         end
         if (cmd.shift) begin
            count_in = count_ff << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      s_ff     <= s_in;
      p_ff     <= p_in;
      count_ff <= count_in;
   end

   assign status.cur_bit   = count_ff[COUNT_BITS-1];
   assign status.res_valid = v0 & v1;
   assign rsp_series_sum   = s_ff;

endmodule

FILE: hw/rtl/gss_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// gss_ctrl: sequencer for the bit scan
// Walks the term count from its top bit down, issuing a doubling round once a one
// bit has been seen and, on a one bit, an appending round to the datapath, then strobes the result.
// ============================================================================
module gss_ctrl #(
   parameter int COUNT_BITS = gss_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   input  gss_pkg::dp_status_type status,
   output gss_pkg::dp_cmd_type    cmd
);

   localparam int BL_W = $clog2(COUNT_BITS + 1);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_STEP      = 6'b000010,
      ST_DBL_WAIT  = 6'b000100,
      ST_APP_ISSUE = 6'b001000,
      ST_APP_WAIT  = 6'b010000,
      ST_DONE      = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   logic [BL_W-1:0] bits_left_ff, bits_left_in;
   logic            seen_one_ff, seen_one_in;
   logic            last_bit;

   assign last_bit = (bits_left_ff == BL_W'(1));

   // Next state and datapath commands.
   always_comb begin
      state_in      = state_ff;
      bits_left_in  = bits_left_ff;
      seen_one_in   = seen_one_ff;
      cmd.load      = 1'b0;
      cmd.issue     = 1'b0;
      cmd.op        = gss_pkg::OP_DOUBLE;
      cmd.writeback = 1'b0;
      cmd.shift     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load     = 1'b1;
               bits_left_in = BL_W'(COUNT_BITS);
               seen_one_in  = 1'b0;
               state_in     = ST_STEP;
            end
         end
         ST_STEP: begin
            // Before the first one bit the sum is zero and the power one,
            // so doubling leaves them unchanged and is skipped.
            priority if (seen_one_ff) begin
               cmd.issue = 1'b1;
               cmd.op    = gss_pkg::OP_DOUBLE;
               state_in  = ST_DBL_WAIT;
            end else if (status.cur_bit) begin
               cmd.issue = 1'b1;
               cmd.op    = gss_pkg::OP_APPEND;
               state_in  = ST_APP_WAIT;
            end else begin
               cmd.shift    = 1'b1;
               bits_left_in = bits_left_ff - BL_W'(1);
               state_in     = last_bit ? ST_DONE : ST_STEP;
            end
         end
         ST_DBL_WAIT: begin
            cmd.op = gss_pkg::OP_DOUBLE;
            if (status.res_valid) begin
               cmd.writeback = 1'b1;
               if (status.cur_bit) begin
                  state_in = ST_APP_ISSUE;
               end else begin
                  cmd.shift    = 1'b1;
                  bits_left_in = bits_left_ff - BL_W'(1);
                  state_in     = last_bit ? ST_DONE : ST_STEP;
               end
            end
         end
         ST_APP_ISSUE: begin
            cmd.issue = 1'b1;
            cmd.op    = gss_pkg::OP_APPEND;
            state_in  = ST_APP_WAIT;
         end
         ST_APP_WAIT: begin
            cmd.op = gss_pkg::OP_APPEND;
            if (status.res_valid) begin
               cmd.writeback = 1'b1;
               cmd.shift     = 1'b1;
               seen_one_in   = 1'b1;
               bits_left_in  = bits_left_ff - BL_W'(1);
               state_in      = last_bit ? ST_DONE : ST_STEP;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bits_left_ff <= '0;
         seen_one_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bits_left_ff <= bits_left_in;
         seen_one_ff  <= seen_one_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   // Products only come back while a round is being awaited.
   assert property (@(posedge clock) disable iff (reset)
      status.res_valid |-> (state_ff == ST_DBL_WAIT || state_ff == ST_APP_WAIT))
      else $error("modular product arrived outside a wait state");

   // The result strobe lasts one cycle and the block then takes a new item.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> state_ff == ST_IDLE)
      else $error("result strobe not followed by idle");

   // The bit counter never runs out while bits are still being scanned.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (bits_left_ff != '0))
      else $error("bit scan continued past the last bit");

endmodule

FILE: hw/rtl/geometric_series_sum_mod_prime_top.sv
`timescale 1ns / 1ps
// Sequence: a term count bit above the highest one bit is only shifted out, the highest one bit
//   takes an appending round, every bit below it a doubling round plus, on a one bit, an
//   appending round; each round runs through the four-stage modular multiplier.
// Throughput: one item at a time; busy stays high until the result strobe has been given.
// Reset: synchronous, active high; clears the sequencer and the multiplier valid bits.
// ============================================================================
// geometric_series_sum_mod_prime_top: geometric series sum modulo 1000000007
// Returns 1 + a + ... + a^(n-1) modulo the prime by scanning the bits of n
// and keeping a running power and sum; a zero count gives zero. The result
// is shown for one cycle on rsp_valid and cannot be held off by the receiver.
// ============================================================================
module geometric_series_sum_mod_prime_top #(
   parameter int COUNT_BITS = gss_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [gss_pkg::BASE_W-1:0]   req_base,
   input  logic [gss_pkg::COUNT_W-1:0]  req_term_count,
   output logic                         rsp_valid,
   output logic [gss_pkg::BASE_W-1:0]   rsp_series_sum
);

   gss_pkg::dp_cmd_type    cmd;
   gss_pkg::dp_status_type status;

   // Sequencer.
   gss_ctrl #(
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers and multiplier lanes.
   gss_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_base       (req_base),
      .req_term_count (req_term_count),
      .rsp_series_sum (rsp_series_sum)
   );

endmodule
